// File: hdl/tile_window_splitter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the tile window splitter modules.
// The module that uses them must have signals named clk and rst.
// ----------------------------------------------------------------------------
`ifndef TILE_WINDOW_SPLITTER_MACROS_SVH
`define TILE_WINDOW_SPLITTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TWS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TWS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Widths, status codes, register indexes and shared types of the splitter.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int COORD_W     = 32;
  localparam int CROP_W      = 12;
  localparam int SIZE_W      = 13;
  localparam int LIMIT_W     = 4;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_TILE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TILES_X = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TILES_Y = 2'd3;

  localparam logic [SIZE_W-1:0]  TILE_WIDTH_RESET  = 13'd256;
  localparam logic [SIZE_W-1:0]  TILE_HEIGHT_RESET = 13'd256;
  localparam logic [LIMIT_W-1:0] MAX_TILES_RESET   = 4'd8;

  typedef struct packed {
    logic [SIZE_W-1:0]  tile_width;
    logic [SIZE_W-1:0]  tile_height;
    logic [LIMIT_W-1:0] max_tiles_x;
    logic [LIMIT_W-1:0] max_tiles_y;
  } cfg_t;

  // Geometry of one classified window, handed from front to back.
  typedef struct packed {
    logic [COORD_W-1:0]  cx0;
    logic [COORD_W-1:0]  cy0;
    logic [CROP_W-1:0]   left;
    logic [CROP_W-1:0]   top;
    logic [CROP_W-1:0]   right;
    logic [CROP_W-1:0]   bottom;
    logic [STATUS_W-1:0] status;
  } job_t;

endpackage

// File: hdl/tile_window_splitter.sv
// Each window needs four floor divisions, run one after another on one shared
// radix-4 divider; the front takes no new window until it has pushed the job.
// Within a job, results leave at one item per cycle while the tile side does not stall.
// Reset: synchronous; empties the job queue and loads the register defaults.
// ----------------------------------------------------------------------------
// tile_window_splitter
// Splits a pixel window over a tile grid and emits one item per covered tile
// with its crop margins, or one error item for an empty or oversized window.
// ----------------------------------------------------------------------------
module tile_window_splitter #(
  parameter int MAX_TILES_PER_AXIS = 8,
  parameter int TILE_SIZE_LIMIT    = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tws_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [tws_pkg::SIZE_W-1:0]            cfg_data,
  input  logic                                  win_valid,
  output logic                                  win_stall,
  input  logic signed [tws_pkg::COORD_W-1:0]    win_xmin,
  input  logic signed [tws_pkg::COORD_W-1:0]    win_ymin,
  input  logic signed [tws_pkg::COORD_W-1:0]    win_xmax,
  input  logic signed [tws_pkg::COORD_W-1:0]    win_ymax,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic signed [tws_pkg::COORD_W-1:0]    tile_col,
  output logic signed [tws_pkg::COORD_W-1:0]    tile_row,
  output logic [tws_pkg::CROP_W-1:0]            crop_left,
  output logic [tws_pkg::CROP_W-1:0]            crop_top,
  output logic [tws_pkg::CROP_W-1:0]            crop_right,
  output logic [tws_pkg::CROP_W-1:0]            crop_bottom,
  output logic [tws_pkg::STATUS_W-1:0]          status,
  output logic                                  last
);
  import tws_pkg::*;

  localparam int CNT_W = $clog2(MAX_TILES_PER_AXIS);
  localparam int QW    = $bits(job_t) + 2 * CNT_W;

  cfg_t             cfg;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  job_t             f_job;
  job_t             b_job;
  logic [CNT_W-1:0] f_last_x;
  logic [CNT_W-1:0] f_last_y;
  logic [CNT_W-1:0] b_last_x;
  logic [CNT_W-1:0] b_last_y;
  logic [QW-1:0]    q_in;
  logic [QW-1:0]    q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tile_width  <= TILE_WIDTH_RESET;
      cfg.tile_height <= TILE_HEIGHT_RESET;
      cfg.max_tiles_x <= MAX_TILES_RESET;
      cfg.max_tiles_y <= MAX_TILES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TILE_WIDTH:  cfg.tile_width  <= cfg_data;
        CFG_TILE_HEIGHT: cfg.tile_height <= cfg_data;
        CFG_MAX_TILES_X: cfg.max_tiles_x <= cfg_data[LIMIT_W-1:0];
        CFG_MAX_TILES_Y: cfg.max_tiles_y <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tws_front #(
    .MAX_TILES_PER_AXIS (MAX_TILES_PER_AXIS),
    .TILE_SIZE_LIMIT    (TILE_SIZE_LIMIT),
    .CNT_W              (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .win_valid (win_valid),
    .win_stall (win_stall),
    .win_xmin  (win_xmin),
    .win_ymin  (win_ymin),
    .win_xmax  (win_xmax),
    .win_ymax  (win_ymax),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (f_job),
    .q_last_x  (f_last_x),
    .q_last_y  (f_last_y)
  );

  assign q_in = {f_job, f_last_x, f_last_y};
  assign {b_job, b_last_x, b_last_y} = q_out;

  tws_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  tws_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_job       (b_job),
    .q_last_x    (b_last_x),
    .q_last_y    (b_last_y),
    .q_pop       (q_pop),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .tile_col    (tile_col),
    .tile_row    (tile_row),
    .crop_left   (crop_left),
    .crop_top    (crop_top),
    .crop_right  (crop_right),
    .crop_bottom (crop_bottom),
    .status      (status),
    .last        (last)
  );

endmodule

// File: hdl/tws_div.sv
// ----------------------------------------------------------------------------
// tws_div
// Iterative unsigned divider, two restoring steps per cycle.
// ----------------------------------------------------------------------------
module tws_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tws_pkg::COORD_W-1:0] dividend,
  input  logic [tws_pkg::SIZE_W-1:0]  divisor,
  output logic                       done,
  output logic [tws_pkg::COORD_W-1:0] quotient,
  output logic [tws_pkg::SIZE_W-1:0]  remainder
);
  import tws_pkg::*;

  localparam int STEPS = COORD_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [COORD_W-1:0] quo;
  logic [SIZE_W-1:0]  rem;

  logic [SIZE_W:0]   t1;
  logic [SIZE_W:0]   t2;
  logic              qa;
  logic              qb;
  logic [SIZE_W-1:0] ra;
  logic [SIZE_W-1:0] rb;

  // The partial remainder stays below the divisor, so each new remainder fits SIZE_W bits.
  always_comb begin
    t1 = {rem, quo[COORD_W-1]};
    qa = (t1 >= {1'b0, divisor});
    ra = qa ? SIZE_W'(t1 - {1'b0, divisor}) : t1[SIZE_W-1:0];
    t2 = {ra, quo[COORD_W-2]};
    qb = (t2 >= {1'b0, divisor});
    rb = qb ? SIZE_W'(t2 - {1'b0, divisor}) : t2[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CNT_W'(STEPS - 1);
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      quo <= {quo[COORD_W-3:0], qa, qb};
      rem <= rb;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// File: hdl/tws_front.sv
// ----------------------------------------------------------------------------
// tws_front
// Accepts a window, finds its first and last tile on each axis by floor
// division, classifies it and pushes a job into the queue.
// ----------------------------------------------------------------------------
`include "tile_window_splitter_macros.svh"

module tws_front #(
  parameter int MAX_TILES_PER_AXIS = 8,
  parameter int TILE_SIZE_LIMIT    = 4096,
  parameter int CNT_W              = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tws_pkg::cfg_t               cfg,
  input  logic                        win_valid,
  output logic                        win_stall,
  input  logic signed [tws_pkg::COORD_W-1:0] win_xmin,
  input  logic signed [tws_pkg::COORD_W-1:0] win_ymin,
  input  logic signed [tws_pkg::COORD_W-1:0] win_xmax,
  input  logic signed [tws_pkg::COORD_W-1:0] win_ymax,
  input  logic                        q_full,
  output logic                        q_push,
  output tws_pkg::job_t               q_job,
  output logic [CNT_W-1:0]            q_last_x,
  output logic [CNT_W-1:0]            q_last_y
);
  import tws_pkg::*;

  localparam int WIDE_W = COORD_W + 1;
  localparam int NB_W   = COORD_W + 2;

  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_START = 2'd1;
  localparam logic [1:0] F_WAIT  = 2'd2;
  localparam logic [1:0] F_PUSH  = 2'd3;

  localparam logic [1:0] STEP_XMIN = 2'd0;
  localparam logic [1:0] STEP_XMAX = 2'd1;
  localparam logic [1:0] STEP_YMIN = 2'd2;
  localparam logic [1:0] STEP_YMAX = 2'd3;

  logic [1:0] state;
  logic [1:0] step;

  logic signed [COORD_W-1:0] xmin;
  logic signed [COORD_W-1:0] ymin;
  logic signed [COORD_W-1:0] xmax;
  logic signed [COORD_W-1:0] ymax;

  logic signed [WIDE_W-1:0] floor_q [4];
  logic [SIZE_W-1:0]        rem_q   [4];

  logic [SIZE_W-1:0]  tw;
  logic [SIZE_W-1:0]  th;
  logic [LIMIT_W-1:0] limx;
  logic [LIMIT_W-1:0] limy;

  logic signed [WIDE_W-1:0] dvd;
  logic [SIZE_W-1:0]        dvs;
  logic                     neg;
  logic [COORD_W-1:0]       mag;
  logic                     div_start;
  logic                     div_done;
  logic [COORD_W-1:0]       div_quo;
  logic [SIZE_W-1:0]        div_rem;
  logic signed [WIDE_W-1:0] fq;
  logic [SIZE_W-1:0]        frem;

  logic signed [NB_W-1:0] nbx;
  logic signed [NB_W-1:0] nby;
  logic signed [NB_W-1:0] limx_s;
  logic signed [NB_W-1:0] limy_s;
  logic [SIZE_W-1:0]      right_full;
  logic [SIZE_W-1:0]      bottom_full;

  // Tile sizes of zero act as one; sizes and limits saturate at their maxima.
  always_comb begin
    if (cfg.tile_width == '0) begin
      tw = SIZE_W'(1);
    end else if (int'(cfg.tile_width) > TILE_SIZE_LIMIT) begin
      tw = SIZE_W'(TILE_SIZE_LIMIT);
    end else begin
      tw = cfg.tile_width;
    end
    if (cfg.tile_height == '0) begin
      th = SIZE_W'(1);
    end else if (int'(cfg.tile_height) > TILE_SIZE_LIMIT) begin
      th = SIZE_W'(TILE_SIZE_LIMIT);
    end else begin
      th = cfg.tile_height;
    end
    limx = (int'(cfg.max_tiles_x) > MAX_TILES_PER_AXIS) ? LIMIT_W'(MAX_TILES_PER_AXIS)
                                                        : cfg.max_tiles_x;
    limy = (int'(cfg.max_tiles_y) > MAX_TILES_PER_AXIS) ? LIMIT_W'(MAX_TILES_PER_AXIS)
                                                        : cfg.max_tiles_y;
  end

  always_comb begin
    unique case (step)
      STEP_XMIN: begin
        dvd = {xmin[COORD_W-1], xmin};
        dvs = tw;
      end
      STEP_XMAX: begin
        dvd = {xmax[COORD_W-1], xmax} - WIDE_W'(1);
        dvs = tw;
      end
      STEP_YMIN: begin
        dvd = {ymin[COORD_W-1], ymin};
        dvs = th;
      end
      STEP_YMAX: begin
        dvd = {ymax[COORD_W-1], ymax} - WIDE_W'(1);
        dvs = th;
      end
      default: begin
        dvd = '0;
        dvs = tw;
      end
    endcase
  end

  // For a negative value a, floor(a / d) = ~(~a / d) and the non-negative
  // remainder is d - 1 - (~a % d), so the divider only sees magnitudes.
  assign neg  = dvd[WIDE_W-1];
  assign mag  = neg ? ~dvd[COORD_W-1:0] : dvd[COORD_W-1:0];
  assign fq   = neg ? ~{1'b0, div_quo} : {1'b0, div_quo};
  assign frem = neg ? (dvs - SIZE_W'(1) - div_rem) : div_rem;

  assign div_start = (state == F_START);

  tws_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .divisor   (dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= STEP_XMIN;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (win_valid) begin
            step  <= STEP_XMIN;
            state <= F_START;
          end
        end
        F_START: begin
          state <= F_WAIT;
        end
        F_WAIT: begin
          if (div_done) begin
            if (step == STEP_YMAX) begin
              state <= F_PUSH;
            end else begin
              step  <= step + 1'b1;
              state <= F_START;
            end
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && win_valid) begin
      xmin <= win_xmin;
      ymin <= win_ymin;
      xmax <= win_xmax;
      ymax <= win_ymax;
    end
    if (state == F_WAIT && div_done) begin
      floor_q[step] <= fq;
      rem_q[step]   <= frem;
    end
  end

  assign win_stall = (state != F_IDLE);
  assign q_push    = (state == F_PUSH) && !q_full;

  always_comb begin
    nbx    = NB_W'(floor_q[STEP_XMAX]) - NB_W'(floor_q[STEP_XMIN]) + NB_W'(1);
    nby    = NB_W'(floor_q[STEP_YMAX]) - NB_W'(floor_q[STEP_YMIN]) + NB_W'(1);
    limx_s = $signed({{(NB_W-LIMIT_W){1'b0}}, limx});
    limy_s = $signed({{(NB_W-LIMIT_W){1'b0}}, limy});
    right_full  = tw - SIZE_W'(1) - rem_q[STEP_XMAX];
    bottom_full = th - SIZE_W'(1) - rem_q[STEP_YMAX];

    q_job.cx0    = floor_q[STEP_XMIN][COORD_W-1:0];
    q_job.cy0    = floor_q[STEP_YMIN][COORD_W-1:0];
    q_job.left   = rem_q[STEP_XMIN][CROP_W-1:0];
    q_job.top    = rem_q[STEP_YMIN][CROP_W-1:0];
    q_job.right  = right_full[CROP_W-1:0];
    q_job.bottom = bottom_full[CROP_W-1:0];

    // Columns are checked before rows, the limit before emptiness.
    if (nbx >= limx_s) begin
      q_job.status = ST_TOO_MANY;
    end else if (nbx <= NB_W'(0)) begin
      q_job.status = ST_EMPTY;
    end else if (nby >= limy_s) begin
      q_job.status = ST_TOO_MANY;
    end else if (nby <= NB_W'(0)) begin
      q_job.status = ST_EMPTY;
    end else begin
      q_job.status = ST_OK;
    end

    q_last_x = nbx[CNT_W-1:0] - CNT_W'(1);
    q_last_y = nby[CNT_W-1:0] - CNT_W'(1);
  end

  `TWS_ASSERT_IMPL(a_done_while_waiting, div_done, state == F_WAIT, "divider finished outside the wait state")

endmodule

// File: hdl/tws_queue.sv
// ----------------------------------------------------------------------------
// tws_queue
// Two-entry queue of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
module tws_queue #(
  parameter int DATA_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);
  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end
  end

  assign full     = (count == (PTR_W + 1)'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

endmodule

// File: hdl/tws_back.sv
// ----------------------------------------------------------------------------
// tws_back
// Walks the tile grid of one job row by row and drives the result register.
// ----------------------------------------------------------------------------
`include "tile_window_splitter_macros.svh"

module tws_back #(
  parameter int CNT_W = 3
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_empty,
  input  tws_pkg::job_t                      q_job,
  input  logic [CNT_W-1:0]                   q_last_x,
  input  logic [CNT_W-1:0]                   q_last_y,
  output logic                               q_pop,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic signed [tws_pkg::COORD_W-1:0] tile_col,
  output logic signed [tws_pkg::COORD_W-1:0] tile_row,
  output logic [tws_pkg::CROP_W-1:0]         crop_left,
  output logic [tws_pkg::CROP_W-1:0]         crop_top,
  output logic [tws_pkg::CROP_W-1:0]         crop_right,
  output logic [tws_pkg::CROP_W-1:0]         crop_bottom,
  output logic [tws_pkg::STATUS_W-1:0]       status,
  output logic                               last
);
  import tws_pkg::*;

  logic             active;
  job_t             job;
  logic [CNT_W-1:0] lx;
  logic [CNT_W-1:0] ly;
  logic [CNT_W-1:0] x;
  logic [CNT_W-1:0] y;
  logic             out_free;
  logic             err;
  logic             end_x;
  logic             end_y;
  logic             emit;

  assign q_pop    = !active && !q_empty;
  assign out_free = !res_valid || !res_stall;
  assign err      = (job.status != ST_OK);
  assign end_x    = err || (x == lx);
  assign end_y    = err || (y == ly);
  assign emit     = active && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
      end else if (emit && end_x && end_y) begin
        active <= 1'b0;
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (out_free) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
      lx  <= q_last_x;
      ly  <= q_last_y;
      x   <= '0;
      y   <= '0;
    end else if (emit) begin
      if (end_x) begin
        x <= '0;
        y <= y + 1'b1;
      end else begin
        x <= x + 1'b1;
      end
    end

    if (emit) begin
      if (err) begin
        // A rejected window yields one zeroed item that carries the status.
        tile_col    <= '0;
        tile_row    <= '0;
        crop_left   <= '0;
        crop_top    <= '0;
        crop_right  <= '0;
        crop_bottom <= '0;
        status      <= job.status;
        last        <= 1'b1;
      end else begin
        tile_col    <= $signed(job.cx0 + COORD_W'(x));
        tile_row    <= $signed(job.cy0 + COORD_W'(y));
        crop_left   <= (x == '0) ? job.left : '0;
        crop_top    <= (y == '0) ? job.top : '0;
        crop_right  <= end_x ? job.right : '0;
        crop_bottom <= end_y ? job.bottom : '0;
        status      <= ST_OK;
        last        <= end_x && end_y;
      end
    end
  end

  `TWS_ASSERT_NEXT(a_pop_starts_job, q_pop, active, "job popped but grid walk did not start")
  `TWS_ASSERT_IMPL(a_error_alone, res_valid && status != ST_OK, last && tile_col == '0 && crop_left == '0, "error item must be a zeroed final item")
  `TWS_ASSERT_IMPL(a_walk_in_grid, active && !err, x <= lx && y <= ly, "grid counters ran past the window")

endmodule

// File: tb/tile_window_splitter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_window_splitter_checker
// Watches the register, window and tile channels of the splitter. It keeps
// its own copy of the registers, works out the tile items that each accepted
// window must produce, and compares every tile item with the oldest one due.
// ----------------------------------------------------------------------------
module tile_window_splitter_checker #(
  parameter int MAX_TILES_PER_AXIS = 8,
  parameter int TILE_SIZE_LIMIT    = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [tws_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tws_pkg::SIZE_W-1:0]         cfg_data,
  input  logic                               win_valid,
  input  logic                               win_stall,
  input  logic signed [tws_pkg::COORD_W-1:0] win_xmin,
  input  logic signed [tws_pkg::COORD_W-1:0] win_ymin,
  input  logic signed [tws_pkg::COORD_W-1:0] win_xmax,
  input  logic signed [tws_pkg::COORD_W-1:0] win_ymax,
  input  logic                               res_valid,
  input  logic                               res_stall,
  input  logic signed [tws_pkg::COORD_W-1:0] tile_col,
  input  logic signed [tws_pkg::COORD_W-1:0] tile_row,
  input  logic [tws_pkg::CROP_W-1:0]         crop_left,
  input  logic [tws_pkg::CROP_W-1:0]         crop_top,
  input  logic [tws_pkg::CROP_W-1:0]         crop_right,
  input  logic [tws_pkg::CROP_W-1:0]         crop_bottom,
  input  logic [tws_pkg::STATUS_W-1:0]       status,
  input  logic                               last,
  output int                                 mismatches,
  output int                                 pending
);
  import tws_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [CROP_W-1:0]   left;
    logic [CROP_W-1:0]   top;
    logic [CROP_W-1:0]   right;
    logic [CROP_W-1:0]   bottom;
    logic [STATUS_W-1:0] status;
    logic                last_flag;
  } tile_item_t;

  tile_item_t tiles_due[$];
  tile_item_t want;

  logic [SIZE_W-1:0]  tile_w_reg;
  logic [SIZE_W-1:0]  tile_h_reg;
  logic [LIMIT_W-1:0] max_x_reg;
  logic [LIMIT_W-1:0] max_y_reg;
  int                 items_seen;

  // Floor division for a positive divisor; SystemVerilog truncates toward zero.
  function automatic longint floor_quot(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d != 0) && (a < 0)) q = q - 1;
    return q;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t: tile item %0d: %s", $realtime, items_seen, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val) report_mismatch($sformatf("%s is %0h, should be %0h", name, got, exp_val));
  endtask

  task automatic push_reject(input logic [STATUS_W-1:0] st);
    tile_item_t e;
    e           = '0;
    e.status    = st;
    e.last_flag = 1'b1;
    tiles_due   = {tiles_due, e};
  endtask

  task automatic predict_tiles(input logic signed [31:0] xmin, input logic signed [31:0] ymin,
                               input logic signed [31:0] xmax, input logic signed [31:0] ymax);
    longint tw, th, limx, limy;
    longint x0, x1, y0, y1, cx0, cx1, cy0, cy1, nbx, nby;
    longint lft, tp, rgt, btm, tx, ty;
    tile_item_t t;
    if (tile_w_reg == 0) tw = 1;
    else if (tile_w_reg > TILE_SIZE_LIMIT) tw = TILE_SIZE_LIMIT;
    else tw = tile_w_reg;
    if (tile_h_reg == 0) th = 1;
    else if (tile_h_reg > TILE_SIZE_LIMIT) th = TILE_SIZE_LIMIT;
    else th = tile_h_reg;
    limx = (max_x_reg > MAX_TILES_PER_AXIS) ? MAX_TILES_PER_AXIS : max_x_reg;
    limy = (max_y_reg > MAX_TILES_PER_AXIS) ? MAX_TILES_PER_AXIS : max_y_reg;

    // The end coordinates are exclusive; subtract in 64 bits so the minimum
    // value does not wrap.
    x0  = xmin;
    y0  = ymin;
    x1  = longint'(xmax) - 1;
    y1  = longint'(ymax) - 1;
    cx0 = floor_quot(x0, tw);
    cx1 = floor_quot(x1, tw);
    cy0 = floor_quot(y0, th);
    cy1 = floor_quot(y1, th);
    nbx = cx1 - cx0 + 1;
    nby = cy1 - cy0 + 1;

    if (nbx >= limx) push_reject(ST_TOO_MANY);
    else if (nbx <= 0) push_reject(ST_EMPTY);
    else if (nby >= limy) push_reject(ST_TOO_MANY);
    else if (nby <= 0) push_reject(ST_EMPTY);
    else begin
      lft = x0 - cx0 * tw;
      tp  = y0 - cy0 * th;
      rgt = tw - (x1 - cx1 * tw) - 1;
      btm = th - (y1 - cy1 * th) - 1;
      for (ty = 0; ty < nby; ty++) begin
        for (tx = 0; tx < nbx; tx++) begin
          t.col       = 32'(cx0 + tx);
          t.row       = 32'(cy0 + ty);
          t.left      = (tx == 0) ? 12'(lft) : '0;
          t.top       = (ty == 0) ? 12'(tp) : '0;
          t.right     = (tx == nbx - 1) ? 12'(rgt) : '0;
          t.bottom    = (ty == nby - 1) ? 12'(btm) : '0;
          t.status    = ST_OK;
          t.last_flag = (tx == nbx - 1) && (ty == nby - 1);
          tiles_due   = {tiles_due, t};
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tile_w_reg = TILE_WIDTH_RESET;
      tile_h_reg = TILE_HEIGHT_RESET;
      max_x_reg  = MAX_TILES_RESET;
      max_y_reg  = MAX_TILES_RESET;
      tiles_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TILE_WIDTH:  tile_w_reg = cfg_data;
          CFG_TILE_HEIGHT: tile_h_reg = cfg_data;
          CFG_MAX_TILES_X: max_x_reg  = cfg_data[LIMIT_W-1:0];
          CFG_MAX_TILES_Y: max_y_reg  = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (win_valid && !win_stall) predict_tiles(win_xmin, win_ymin, win_xmax, win_ymax);
      if (res_valid && !res_stall) begin
        if (tiles_due.size() == 0) begin
          report_mismatch("tile item arrived with none due");
        end else begin
          want = tiles_due.pop_front();
          check_field("tile_col", tile_col, want.col);
          check_field("tile_row", tile_row, want.row);
          check_field("crop_left", 32'(crop_left), 32'(want.left));
          check_field("crop_top", 32'(crop_top), 32'(want.top));
          check_field("crop_right", 32'(crop_right), 32'(want.right));
          check_field("crop_bottom", 32'(crop_bottom), 32'(want.bottom));
          check_field("status", 32'(status), 32'(want.status));
          check_field("last", 32'(last), 32'(want.last_flag));
        end
        items_seen++;
      end
    end
    pending = tiles_due.size();
  end

endmodule

// File: tb/tile_window_splitter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_window_splitter_tb
// Drives windows and register writes into the tile window splitter with
// random gaps and back-pressure, including one long hold-off on the tile
// side, and reports the verdict of the checker that runs beside the block.
// ----------------------------------------------------------------------------
module tile_window_splitter_tb;
  import tws_pkg::*;

  localparam int     MAX_TILES   = 8;
  localparam int     SIZE_LIMIT  = 4096;
  localparam int     QUIET_LIMIT = 5000;
  localparam int     HOLD_CYCLES = 700;
  localparam int     PRESSURE_AT = 200;
  localparam int     END_CYCLES  = 100;
  localparam longint COORD_MIN   = -64'sd2147483648;
  localparam longint COORD_MAX   = 64'sd2147483647;

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_W-1:0]     cfg_index;
  logic [SIZE_W-1:0]          cfg_data;
  logic                       win_valid;
  logic                       win_stall;
  logic signed [COORD_W-1:0]  win_xmin;
  logic signed [COORD_W-1:0]  win_ymin;
  logic signed [COORD_W-1:0]  win_xmax;
  logic signed [COORD_W-1:0]  win_ymax;
  logic                       res_valid;
  logic                       res_stall = 1'b1;
  logic signed [COORD_W-1:0]  tile_col;
  logic signed [COORD_W-1:0]  tile_row;
  logic [CROP_W-1:0]          crop_left;
  logic [CROP_W-1:0]          crop_top;
  logic [CROP_W-1:0]          crop_right;
  logic [CROP_W-1:0]          crop_bottom;
  logic [STATUS_W-1:0]        status;
  logic                       last;

  int     mismatch_count;
  int     tiles_pending;
  int     window_count = 0;
  int     quiet_cycles = 0;
  int     rx_wait = 0;
  int     rx_draw;
  logic   rx_calm = 1'b0;
  logic   tx_calm = 1'b0;
  logic   hold_active = 1'b0;
  longint tw_eff = 256;
  longint th_eff = 256;
  longint limx_eff = 8;
  longint limy_eff = 8;

  tile_window_splitter #(
    .MAX_TILES_PER_AXIS(MAX_TILES),
    .TILE_SIZE_LIMIT   (SIZE_LIMIT)
  ) uut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .win_valid, .win_stall, .win_xmin, .win_ymin, .win_xmax, .win_ymax,
    .res_valid, .res_stall, .tile_col, .tile_row, .crop_left, .crop_top,
    .crop_right, .crop_bottom, .status, .last
  );

  tile_window_splitter_checker #(
    .MAX_TILES_PER_AXIS(MAX_TILES),
    .TILE_SIZE_LIMIT   (SIZE_LIMIT)
  ) tile_check (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .win_valid, .win_stall, .win_xmin, .win_ymin, .win_xmax, .win_ymax,
    .res_valid, .res_stall, .tile_col, .tile_row, .crop_left, .crop_top,
    .crop_right, .crop_bottom, .status, .last,
    .mismatches(mismatch_count), .pending(tiles_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Tile side: after each accepted item it stalls for a drawn number of
  // cycles, and stays stalled while the long hold-off runs.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b1;
      rx_wait   <= 0;
    end else if (hold_active) begin
      res_stall <= 1'b1;
    end else if (res_valid && !res_stall) begin
      if ($urandom_range(0, 23) == 0) rx_calm = !rx_calm;
      rx_draw = rx_calm ? 0 : $urandom_range(0, 18);
      rx_wait   <= rx_draw;
      res_stall <= (rx_draw != 0);
    end else if (rx_wait > 1) begin
      rx_wait   <= rx_wait - 1;
      res_stall <= 1'b1;
    end else begin
      rx_wait   <= 0;
      res_stall <= 1'b0;
    end
  end

  // Long hold-off so the block fills up and has to stall the window side.
  initial begin
    do @(posedge clk); while (window_count < PRESSURE_AT);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (win_valid && !win_stall) ||
        (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tile_window_splitter_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_window(input logic [31:0] xmin, input logic [31:0] ymin,
                             input logic [31:0] xmax, input logic [31:0] ymax);
    int gap;
    if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      win_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    win_valid <= 1'b1;
    win_xmin  <= xmin;
    win_ymin  <= ymin;
    win_xmax  <= xmax;
    win_ymax  <= ymax;
    @(posedge clk);
    while (win_stall) @(posedge clk);
    window_count <= window_count + 1;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_config(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                              input logic [SIZE_W-1:0] mx, input logic [SIZE_W-1:0] my);
    write_reg(CFG_TILE_WIDTH, w);
    write_reg(CFG_TILE_HEIGHT, h);
    write_reg(CFG_MAX_TILES_X, mx);
    write_reg(CFG_MAX_TILES_Y, my);
    cfg_valid <= 1'b0;
    tw_eff   = (w == 0) ? 1 : ((w > SIZE_LIMIT) ? SIZE_LIMIT : w);
    th_eff   = (h == 0) ? 1 : ((h > SIZE_LIMIT) ? SIZE_LIMIT : h);
    limx_eff = (mx[LIMIT_W-1:0] > MAX_TILES) ? MAX_TILES : mx[LIMIT_W-1:0];
    limy_eff = (my[LIMIT_W-1:0] > MAX_TILES) ? MAX_TILES : my[LIMIT_W-1:0];
  endtask

  // Stops offering windows and waits until every tile item due has come out.
  task automatic wait_until_idle();
    win_valid <= 1'b0;
    do @(negedge clk); while (tiles_pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // One axis of a window. Most spans cover a legal number of tiles placed
  // anywhere in the coordinate range; the rest reach the tile limit, or are reversed, empty or noise.
  task automatic pick_span(input longint s, input longint lim,
                           output logic [31:0] lo, output logic [31:0] hi);
    longint n, c0, cmin, cmax, lo_v, hi_v, lo_off, hi_off;
    longint unsigned r;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 84) begin
      if (lim >= 2 && $urandom_range(0, 9) != 0) n = $urandom_range(1, lim - 1);
      else if (lim >= 1) n = lim;
      else n = $urandom_range(1, 3);
      cmin = -(64'sd2147483648 / s);
      cmax = COORD_MAX / s - n;
      case ($urandom_range(0, 3))
        0: c0 = longint'($urandom_range(0, 40)) - 20;
        1: begin
          r  = {$urandom, $urandom};
          c0 = cmin + longint'(r % longint'(cmax - cmin + 1));
        end
        2: c0 = cmax - longint'($urandom_range(0, 3));
        default: c0 = cmin + longint'($urandom_range(0, 3));
      endcase
      lo_off = $urandom_range(0, s - 1);
      if (n == 1) hi_off = $urandom_range(lo_off + 1, s);
      else hi_off = $urandom_range(1, s);
      lo_v = c0 * s + lo_off;
      hi_v = (c0 + n - 1) * s + hi_off;
    end else if (kind < 92) begin
      lo_v = longint'($signed($urandom));
      hi_v = lo_v - longint'($urandom_range(0, 3 * s));
      if (hi_v < COORD_MIN) hi_v = COORD_MIN;
    end else begin
      lo_v = longint'($signed($urandom));
      hi_v = longint'($signed($urandom));
    end
    lo = lo_v[31:0];
    hi = hi_v[31:0];
  endtask

  task automatic run_random(input int count);
    logic [31:0] xl, xh, yl, yh;
    repeat (count) begin
      pick_span(tw_eff, limx_eff, xl, xh);
      pick_span(th_eff, limy_eff, yl, yh);
      send_window(xl, yl, xh, yh);
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] w, h;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    win_valid <= 1'b0;
    win_xmin  <= '0;
    win_ymin  <= '0;
    win_xmax  <= '0;
    win_ymax  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed windows on the reset settings: 256 x 256 tiles, limit 8.
    send_window(0, 0, 256, 256);
    send_window(1, 2, 255, 254);
    send_window(-256, -512, 0, -256);     // exact negative multiples
    send_window(-257, -1, -255, 1);
    send_window(-1, -1, 1, 1);
    send_window(255, 255, 257, 257);
    send_window(10, 20, 1790, 1780);      // largest legal grid, 7 x 7
    send_window(0, 0, 2048, 10);          // too many columns
    send_window(0, 0, 10, 2048);          // too many rows
    send_window(0, 0, 0, 10);             // zero width
    send_window(5, 0, 5, 10);
    send_window(1000, 0, 0, 10);          // negative column count
    send_window(0, 1000, 4096, 0);        // column check wins over rows
    send_window(0, 256, 10, 0);           // rows reversed
    send_window(0, 0, 0, 4096);           // empty columns, too many rows
    send_window(32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 32'h8000_0001);
    send_window(32'h7fff_fffe, 32'h7fff_fffe, 32'h7fff_ffff, 32'h7fff_ffff);
    send_window(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_window(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_window(32'h8000_0000, 0, 32'h8000_0000, 10);
    run_random(30);

    wait_until_idle();
    apply_config(13'd1, 13'd1, 13'd15, 13'h1ff9);
    run_random(40);

    // A zero width acts as one, an oversized height as the size limit, and
    // a zero column limit rejects everything.
    wait_until_idle();
    apply_config(13'd0, 13'h1fff, 13'd0, 13'd9);
    run_random(10);

    wait_until_idle();
    apply_config(13'd4096, 13'd4096, 13'd1, 13'd8);
    run_random(10);

    wait_until_idle();
    apply_config(13'd4096, 13'd1, 13'd8, 13'd2);
    run_random(25);

    repeat (5) begin
      w = ($urandom_range(0, 3) == 0) ? 13'(1 << $urandom_range(0, 12)) : 13'($urandom_range(1, 64));
      h = ($urandom_range(0, 3) == 0) ? 13'(1 << $urandom_range(0, 12)) : 13'($urandom_range(1, 64));
      wait_until_idle();
      apply_config(w, h, {9'($urandom), 4'($urandom_range(2, 8))},
                   {9'($urandom), 4'($urandom_range(2, 8))});
      run_random(28);
    end

    wait_until_idle();
    repeat (END_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && tiles_pending == 0) begin
      $display("tile_window_splitter_tb: clean");
    end else begin
      $display("tile_window_splitter_tb: errors");
    end
    $finish;
  end

endmodule
